@@ sv/blgc_pkg.sv @@
// Package for the beat-loop gesture controller: action and phase codes,
// division table and stream field offsets. No dependencies.
`default_nettype none

package blgc_pkg;

    // Result kind carried in the master-side tuser
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_ARM    = 3'd1,
        ACT_ENTER  = 3'd2,
        ACT_LATCH  = 3'd3,
        ACT_RESIZE = 3'd4,
        ACT_EXIT   = 3'd5
    } t_action;

    // Loop phase, one-hot
    typedef enum logic [2:0] {
        PH_OFF = 3'b001,
        PH_MOM = 3'b010,
        PH_LAT = 3'b100
    } t_phase;

    // Loop mode codes as they appear on the result
    localparam logic [1:0] LOOP_OFF = 2'd0;
    localparam logic [1:0] LOOP_MOM = 2'd1;
    localparam logic [1:0] LOOP_LAT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SONG_LENGTH = 2'd0;
    localparam logic [1:0] CFG_BEAT_FRAMES = 2'd1;
    localparam logic [1:0] CFG_HOLD_MS     = 2'd2;

    localparam int          CFG_IDX_W   = 2;
    localparam int          CFG_DATA_W  = 32;
    localparam int          BEAT_W      = 24;
    localparam int          HOLD_W      = 16;
    localparam logic [15:0] HOLD_RESET  = 16'd450;

    // Division: 0 half beat, 1 beat, 2 two beats, 3 one bar
    localparam logic [1:0] SEL_MIN   = 2'd0;
    localparam logic [1:0] SEL_MAX   = 2'd3;
    localparam logic [1:0] SEL_RESET = 2'd3;
    localparam int         NUM_W     = 3;
    localparam logic [NUM_W-1:0] DIV_NUM [4] = '{3'd1, 3'd1, 3'd2, 3'd4};
    localparam logic [1:0]       DIV_DEN [4] = '{2'd2, 2'd1, 2'd1, 2'd1};
    localparam logic [1:0]       DEN_HALF    = 2'd2;

    // Slave-side tdata layout
    localparam int S_TDATA_W    = 56;
    localparam int S_PLAY       = 0;
    localparam int S_FUNCTION   = 1;
    localparam int S_RUNNING    = 2;
    localparam int S_VOL_DOWN   = 3;
    localparam int S_VOL_UP     = 4;
    localparam int S_HELD_LSB   = 5;
    localparam int S_PH_LSB     = 21;

    // Master-side tdata layout
    localparam int M_TDATA_W     = 136;
    localparam int M_TDATA_PAD   = 4;
    localparam int M_LOOP_LSB    = 128;

endpackage

`default_nettype wire

@@ sv/blgc_win_len.sv @@
// Loop window length: beat length times the division, clamped to the room
// left in the song. Uses blgc_pkg.
`default_nettype none

module blgc_win_len
    import blgc_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  wire logic [BEAT_W-1:0]     i_beat_frames,
    input  wire logic [1:0]            i_sel,
    input  wire logic [FRAME_BITS-1:0] i_start,
    input  wire logic [FRAME_BITS-1:0] i_song,
    output logic      [FRAME_BITS-1:0] o_len
);

    localparam int PROD_W = BEAT_W + NUM_W;
    localparam int LW     = (FRAME_BITS > PROD_W) ? FRAME_BITS : PROD_W;

    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     beat_len;
    logic [FRAME_BITS-1:0] room;
    logic [LW-1:0]         beat_len_x;
    logic [LW-1:0]         room_x;

    // Scale the beat by the division; the only fraction is a half
    assign prod     = PROD_W'(i_beat_frames) * PROD_W'(DIV_NUM[i_sel]);
    assign beat_len = (DIV_DEN[i_sel] == DEN_HALF) ? (prod >> 1) : prod;

    assign room       = i_song - i_start;
    assign beat_len_x = LW'(beat_len);
    assign room_x     = LW'(room);

    // Zero means no window; clamp to the song end otherwise
    always_comb begin
        if (i_beat_frames == '0 || i_start >= i_song || beat_len == '0) begin
            o_len = '0;
        end else if (beat_len_x > room_x) begin
            o_len = room;
        end else begin
            o_len = FRAME_BITS'(beat_len);
        end
    end

endmodule

`default_nettype wire

@@ sv/beat_loop_gesture_controller_core.sv @@
// Beat-loop gesture controller top level: input register, one pass of gesture
// and playhead logic, result register. Uses blgc_pkg and blgc_win_len.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata buttons, held_ms, playhead; tuser mode
//  m_*       out  m_tvalid/m_tready  tdata playhead and window; tuser action
//  i_cfg_*   in   i_cfg_we           i_cfg_idx register, i_cfg_data value
//
// One beat per cycle sustained while m_tready stays high; each beat's result is
// offered on m_* once it has passed the input register, then the result register.
// The window-length units and the window-end adder sit in the single pass between
// the two registers. Reset (i_rst_n low, synchronous) empties both registers and
// loads the register defaults. A stalled result holds the result register, and
// the input register fills behind it.
`default_nettype none

module beat_loop_gesture_controller_core
    import blgc_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // play, function, running, vol_down, vol_up, held_ms[15:0], playhead[31:0]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // mode
    input  wire logic                  s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // next_playhead, resume_at, window_start, window_end, loop_mode, division
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // action
    output logic      [2:0]            m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration
    logic [31:0]           r_song_length;
    logic [BEAT_W-1:0]     r_beat_frames;
    logic [HOLD_W-1:0]     r_hold_ms;

    // Input register and result register
    logic                  r_in_valid;
    logic [S_TDATA_W-1:0]  r_in_data;
    logic                  r_in_user;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;
    logic [2:0]            r_out_user;

    // Gesture state
    t_phase                r_phase,        n_phase;
    logic [FRAME_BITS-1:0] r_start,        n_start;
    logic [FRAME_BITS-1:0] r_end,          n_end;
    logic [FRAME_BITS-1:0] r_resume,       n_resume;
    logic [FRAME_BITS-1:0] r_armed_start,  n_armed_start;
    logic                  r_armed_valid,  n_armed_valid;
    logic [1:0]            r_sel,          n_sel;
    logic                  r_swallowed,    n_swallowed;
    logic                  r_play_prev,    n_play_prev;
    logic                  r_fn_prev,      n_fn_prev;
    logic                  r_entered,      n_entered;

    logic                  advance;
    logic                  fire;
    logic                  in_mode;
    logic                  play;
    logic                  fn;
    logic                  running;
    logic                  vdown;
    logic                  vup;
    logic [HOLD_W-1:0]     held;
    logic [FRAME_BITS-1:0] ph;
    logic [FRAME_BITS:0]   ph1;
    logic [FRAME_BITS-1:0] song;
    logic                  play_press;
    logic                  play_lift;
    logic                  fn_edge;
    logic                  arm_try;
    logic                  enter_try;
    logic [FRAME_BITS-1:0] win_start;
    logic [1:0]            sel_up;
    logic [1:0]            sel_new;
    logic [FRAME_BITS-1:0] len_cur;
    logic [FRAME_BITS-1:0] len_new;
    logic [FRAME_BITS-1:0] adv_next;
    t_action               act;
    logic [FRAME_BITS-1:0] nxt;
    logic [1:0]            loop_code;

    function automatic logic [FRAME_BITS-1:0] f_resume(
        input logic [FRAME_BITS-1:0] e,
        input logic [FRAME_BITS-1:0] s
    );
        return (e < s) ? e : '0;
    endfunction

    // Handshake: the input register moves on whenever the result register can
    assign advance  = !r_out_valid || m_tready;
    assign fire     = r_in_valid && advance;
    assign s_tready = !r_in_valid || advance;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_user;

    // Unpack the held beat
    assign in_mode = r_in_user;
    assign play    = r_in_data[S_PLAY];
    assign fn      = r_in_data[S_FUNCTION];
    assign running = r_in_data[S_RUNNING];
    assign vdown   = r_in_data[S_VOL_DOWN];
    assign vup     = r_in_data[S_VOL_UP];
    assign held    = r_in_data[S_HELD_LSB +: HOLD_W];
    assign ph      = r_in_data[S_PH_LSB +: FRAME_BITS];
    assign song    = r_song_length[FRAME_BITS-1:0];
    assign ph1     = {1'b0, ph} + (FRAME_BITS+1)'(1);

    assign play_press = play && !r_play_prev;
    assign play_lift  = !play && r_play_prev;
    assign fn_edge    = fn && !r_fn_prev;

    // Gesture qualifiers; an arm attempt and a loop entry never share a beat
    assign arm_try   = !in_mode && play_press && (r_phase == PH_OFF) && running
                       && !r_swallowed && !fn;
    assign enter_try = !in_mode && !arm_try && (r_phase == PH_OFF) && play
                       && !r_swallowed && r_armed_valid && !(r_entered && !play_press)
                       && running && (held >= r_hold_ms);
    assign win_start = arm_try ? ph : (enter_try ? r_armed_start : r_start);

    // Step up, then down, each clamped
    assign sel_up  = (vup && r_sel < SEL_MAX) ? r_sel + 2'd1 : r_sel;
    assign sel_new = (vdown && sel_up > SEL_MIN) ? sel_up - 2'd1 : sel_up;

    blgc_win_len #(.FRAME_BITS(FRAME_BITS)) u_len_cur (
        .i_beat_frames (r_beat_frames),
        .i_sel         (r_sel),
        .i_start       (win_start),
        .i_song        (song),
        .o_len         (len_cur)
    );

    blgc_win_len #(.FRAME_BITS(FRAME_BITS)) u_len_new (
        .i_beat_frames (r_beat_frames),
        .i_sel         (sel_new),
        .i_start       (win_start),
        .i_song        (song),
        .o_len         (len_new)
    );

    // Playhead advance: wrap inside a running loop, else at the song end
    always_comb begin
        if (r_phase != PH_OFF && r_end > r_start) begin
            if (ph < r_start || ph >= r_end || ph1 >= {1'b0, r_end}) begin
                adv_next = r_start;
            end else begin
                adv_next = ph1[FRAME_BITS-1:0];
            end
        end else if (song != '0 && ph1 >= {1'b0, song}) begin
            adv_next = '0;
        end else begin
            adv_next = ph1[FRAME_BITS-1:0];
        end
    end

    // Gesture pass for one control beat
    always_comb begin
        n_phase       = r_phase;
        n_start       = r_start;
        n_end         = r_end;
        n_resume      = r_resume;
        n_armed_start = r_armed_start;
        n_armed_valid = r_armed_valid;
        n_sel         = r_sel;
        n_swallowed   = r_swallowed;
        n_play_prev   = r_play_prev;
        n_fn_prev     = r_fn_prev;
        n_entered     = r_entered;
        act           = ACT_NONE;
        nxt           = '0;
        if (fire) begin
            if (in_mode) begin
                nxt = adv_next;
            end else begin
                n_play_prev = play;
                n_fn_prev   = fn;
                if (play_press && r_phase == PH_LAT) begin
                    // exit a latched loop and swallow the release
                    n_armed_valid = 1'b0;
                    n_resume      = f_resume(r_end, song);
                    n_phase       = PH_OFF;
                    n_swallowed   = 1'b1;
                    act           = ACT_EXIT;
                end else if (arm_try && len_cur != '0) begin
                    n_entered     = 1'b0;
                    n_armed_start = ph;
                    n_armed_valid = 1'b1;
                    act           = ACT_ARM;
                end else if (play_lift) begin
                    n_armed_valid = 1'b0;
                    n_swallowed   = 1'b0;
                    n_entered     = 1'b0;
                    if (!r_swallowed && r_phase == PH_MOM) begin
                        n_resume = f_resume(r_end, song);
                        n_phase  = PH_OFF;
                        act      = ACT_EXIT;
                    end
                end else begin
                    if (play_press) begin
                        n_entered = 1'b0;
                        if (arm_try) begin
                            n_armed_valid = 1'b0;
                        end
                    end
                    if (fn_edge && r_phase == PH_MOM) begin
                        n_phase = PH_LAT;
                        act     = ACT_LATCH;
                    end
                    // enter the momentary loop at the armed frame
                    if (enter_try) begin
                        n_start   = r_armed_start;
                        n_entered = 1'b1;
                        if (len_cur != '0) begin
                            n_end    = win_start + len_cur;
                            n_resume = f_resume(win_start + len_cur, song);
                            n_phase  = PH_MOM;
                            act      = ACT_ENTER;
                        end
                    end
                    // resize; a rejected step keeps the old division
                    if (n_phase != PH_OFF && (play || fn) && (vdown || vup)
                        && sel_new != r_sel) begin
                        if (len_new != '0) begin
                            n_sel    = sel_new;
                            n_end    = win_start + len_new;
                            n_resume = f_resume(win_start + len_new, song);
                            act      = ACT_RESIZE;
                        end else if (len_cur != '0) begin
                            n_end    = win_start + len_cur;
                            n_resume = f_resume(win_start + len_cur, song);
                        end else begin
                            n_resume = f_resume(n_end, song);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        case (n_phase)
            PH_OFF:  loop_code = LOOP_OFF;
            PH_MOM:  loop_code = LOOP_MOM;
            PH_LAT:  loop_code = LOOP_LAT;
            default: loop_code = LOOP_OFF;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song_length <= '0;
            r_beat_frames <= '0;
            r_hold_ms     <= HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SONG_LENGTH: r_song_length <= i_cfg_data;
                CFG_BEAT_FRAMES: r_beat_frames <= i_cfg_data[BEAT_W-1:0];
                CFG_HOLD_MS:     r_hold_ms     <= i_cfg_data[HOLD_W-1:0];
                default:         r_hold_ms     <= r_hold_ms;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_data <= s_tdata;
            r_in_user <= s_tuser;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {{M_TDATA_PAD{1'b0}}, n_sel, loop_code, 32'(n_end),
                           32'(n_start), 32'(n_resume), 32'(nxt)};
            r_out_user <= act;
        end
    end

    // Gesture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OFF;
            r_start       <= '0;
            r_end         <= '0;
            r_resume      <= '0;
            r_armed_start <= '0;
            r_armed_valid <= 1'b0;
            r_sel         <= SEL_RESET;
            r_swallowed   <= 1'b0;
            r_play_prev   <= 1'b0;
            r_fn_prev     <= 1'b0;
            r_entered     <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_start       <= n_start;
            r_end         <= n_end;
            r_resume      <= n_resume;
            r_armed_start <= n_armed_start;
            r_armed_valid <= n_armed_valid;
            r_sel         <= n_sel;
            r_swallowed   <= n_swallowed;
            r_play_prev   <= n_play_prev;
            r_fn_prev     <= n_fn_prev;
            r_entered     <= n_entered;
        end
    end

endmodule

`default_nettype wire

@@ sv/blgc_checker.sv @@
// Port-level checks on the result stream of the beat-loop controller, and
// the bind that attaches them to the top level. Uses blgc_pkg.
`default_nettype none

module blgc_checker
    import blgc_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [2:0]           m_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled beat stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled beat keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An exit always leaves the loop off
    a_exit_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == ACT_EXIT |-> m_tdata[M_LOOP_LSB +: 2] == LOOP_OFF)
        else $error("exit beat with loop still on");

    // A latch always reports the latched mode
    a_latch_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == ACT_LATCH |-> m_tdata[M_LOOP_LSB +: 2] == LOOP_LAT)
        else $error("latch beat without latched mode");

endmodule

bind beat_loop_gesture_controller_core blgc_checker u_blgc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
